/* rtl/sbda_pkg.sv */
// ----------------------------------------------------------------------------
// sbda_pkg: shared types and constants for signed binary to decimal ASCII
// State encoding, character codes and converter widths.
// ----------------------------------------------------------------------------
`default_nettype none

package sbda_pkg;

  localparam int unsigned VALUE_W = 32;  // input word width
  localparam int unsigned CHAR_W  = 7;   // ASCII code width
  localparam int unsigned NDIGITS = 10;  // decimal digits of a 32-bit magnitude
  localparam int unsigned BCD_W   = 4 * NDIGITS;
  localparam int unsigned BITCNT_W = 5;  // counts VALUE_W shift steps
  localparam int unsigned DIGCNT_W = 4;  // holds 1..NDIGITS

  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 7'd48;  // '0'
  localparam logic [CHAR_W-1:0] CHAR_MINUS = 7'd45;  // '-'
  localparam logic [CHAR_W-1:0] CHAR_NINE  = 7'd57;  // '9'

  typedef enum logic [2:0] {
    ST_IDLE,   // waiting for an input transaction
    ST_CONV,   // shift-add-3 conversion, one magnitude bit per cycle
    ST_STRIP,  // drop leading zero digits, one per cycle
    ST_SIGN,   // emit the minus sign
    ST_EMIT    // emit digits, most significant first
  } state_t;

endpackage : sbda_pkg

`default_nettype wire

/* rtl/signed_binary_to_decimal_ascii.sv */
// ----------------------------------------------------------------------------
// signed_binary_to_decimal_ascii: signed 32-bit integer to decimal text
// Bit-serial double-dabble converter feeding a one-character output register.
// ----------------------------------------------------------------------------
`default_nettype none

// Each input transaction carries one signed 32-bit value; the block returns
// its decimal text as a run of output transactions, one ASCII character each,
// most significant first, with out_last high on the final character. Negative
// values start with '-', zero gives a single '0', and leading zeros never
// appear; the most negative value gives "-2147483648" (11 characters).
// Per item: the value is loaded, then shift-add-3 conversion runs over all 32
// magnitude bits (one magnitude bit per cycle), the strip step drops leading
// zeros (up to 9), and the characters (up to 11) are emitted, each one waiting
// for the sink to be ready. Dropped zeros plus emitted digits always make ten.
// One value is converted at a time: in_ready is high only while the converter
// is idle. The output register lets the final character wait for the sink
// while the next value is already accepted.
module signed_binary_to_decimal_ascii (
  input  wire                             clk,
  input  wire                             rst_n,
  // input channel
  input  wire                             in_valid,
  output logic                            in_ready,
  input  wire signed [sbda_pkg::VALUE_W-1:0] in_value,
  // result channel
  output logic                            out_valid,
  input  wire                             out_ready,
  output logic [sbda_pkg::CHAR_W-1:0]     out_character,
  output logic                            out_last
);

  import sbda_pkg::*;

  // Control state
  state_t               state_r, state_nxt;
  logic [BITCNT_W-1:0]  bitcnt_r, bitcnt_nxt;   // conversion steps left minus one
  logic [DIGCNT_W-1:0]  ndig_r, ndig_nxt;       // digits still to emit
  logic                 out_valid_r, out_valid_nxt;

  // Payload
  logic [VALUE_W-1:0]   mag_r, mag_nxt;         // magnitude, shifted out MSB first
  logic [BCD_W-1:0]     bcd_r, bcd_nxt;         // BCD digits, most significant on top
  logic                 neg_r, neg_nxt;
  logic [CHAR_W-1:0]    char_r, char_nxt;
  logic                 last_r, last_nxt;

  logic                 in_fire;
  logic                 slot_free;              // output register can take a char
  logic [BCD_W-1:0]     bcd_adj;                // digits after the add-3 correction
  logic [3:0]           top_digit;

  assign in_ready      = (state_r == ST_IDLE);
  assign in_fire       = in_valid && in_ready;
  assign slot_free     = !out_valid_r || out_ready;
  assign top_digit     = bcd_r[BCD_W-1 -: 4];

  assign out_valid     = out_valid_r;
  assign out_character = char_r;
  assign out_last      = last_r;

  // Add-3 step: every digit of 5 or more gets 3 added before the shift, so the
  // shifted digit carries correctly into the next decade. Digits are independent.
  always_comb begin
    for (int d = 0; d < NDIGITS; d++) begin
      if (bcd_r[4*d +: 4] >= 4'd5) begin
        bcd_adj[4*d +: 4] = bcd_r[4*d +: 4] + 4'd3;
      end else begin
        bcd_adj[4*d +: 4] = bcd_r[4*d +: 4];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      bitcnt_r    <= '0;
      ndig_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      bitcnt_r    <= bitcnt_nxt;
      ndig_r      <= ndig_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mag_r  <= mag_nxt;
    bcd_r  <= bcd_nxt;
    neg_r  <= neg_nxt;
    char_r <= char_nxt;
    last_r <= last_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    bitcnt_nxt    = bitcnt_r;
    ndig_nxt      = ndig_r;
    mag_nxt       = mag_r;
    bcd_nxt       = bcd_r;
    neg_nxt       = neg_r;
    char_nxt      = char_r;
    last_nxt      = last_r;
    // a taken character frees the output register
    out_valid_nxt = out_valid_r && !out_ready;

    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          neg_nxt    = in_value[VALUE_W-1];
          // unsigned negation covers the most negative value too
          mag_nxt    = in_value[VALUE_W-1] ? (VALUE_W'(0) - VALUE_W'(in_value))
                                           : VALUE_W'(in_value);
          bcd_nxt    = '0;
          bitcnt_nxt = BITCNT_W'(VALUE_W - 1);
          ndig_nxt   = DIGCNT_W'(NDIGITS);
          state_nxt  = ST_CONV;
        end
      end

      ST_CONV: begin
        {bcd_nxt, mag_nxt} = {bcd_adj, mag_r} << 1;
        bitcnt_nxt = bitcnt_r - 1'b1;
        if (bitcnt_r == '0) begin
          state_nxt = ST_STRIP;
        end
      end

      ST_STRIP: begin
        if (top_digit == 4'd0 && ndig_r > DIGCNT_W'(1)) begin
          bcd_nxt  = bcd_r << 4;
          ndig_nxt = ndig_r - 1'b1;
        end else if (neg_r) begin
          state_nxt = ST_SIGN;
        end else begin
          state_nxt = ST_EMIT;
        end
      end

      ST_SIGN: begin
        if (slot_free) begin
          char_nxt      = CHAR_MINUS;
          last_nxt      = 1'b0;  // a digit always follows
          out_valid_nxt = 1'b1;
          state_nxt     = ST_EMIT;
        end
      end

      ST_EMIT: begin
        if (slot_free) begin
          char_nxt      = CHAR_ZERO + {3'b000, top_digit};
          last_nxt      = (ndig_r == DIGCNT_W'(1));
          out_valid_nxt = 1'b1;
          bcd_nxt       = bcd_r << 4;
          ndig_nxt      = ndig_r - 1'b1;
          if (ndig_r == DIGCNT_W'(1)) begin
            state_nxt = ST_IDLE;
          end
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  logic bcd_ok;
  always_comb begin
    bcd_ok = 1'b1;
    for (int d = 0; d < NDIGITS; d++) begin
      if (bcd_r[4*d +: 4] > 4'd9) begin
        bcd_ok = 1'b0;
      end
    end
  end

  // every register digit is a decimal digit in the strip step, after conversion
  a_bcd_digits: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_STRIP) |-> bcd_ok)
    else $error("BCD digit out of range after conversion");

  // digits left to emit stay within one and the maximum
  a_ndig_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SIGN || state_r == ST_EMIT) |->
      (ndig_r != '0 && ndig_r <= DIGCNT_W'(NDIGITS)))
    else $error("digit count out of range");

  // stripping leaves a nonzero leading digit unless only one digit is left
  a_no_lead_zero: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == ST_SIGN || state_r == ST_EMIT) && $past(state_r) == ST_STRIP) |->
      (top_digit != 4'd0 || ndig_r == DIGCNT_W'(1)))
    else $error("leading zero left after strip");

  // only minus or a decimal digit ever leaves the block
  a_char_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |->
      (char_r == CHAR_MINUS || (char_r >= CHAR_ZERO && char_r <= CHAR_NINE)))
    else $error("invalid character code");

  // the minus sign is never the last character of a run
  a_minus_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && char_r == CHAR_MINUS) |-> !last_r)
    else $error("minus sign marked as last");

endmodule : signed_binary_to_decimal_ascii

`default_nettype wire
